// ----- rtl/positional_list_store_defines.svh -----
// Assertion macros shared by the checker of the positional list store.
// Stand-alone header; the using file must provide clk and rst in scope.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PLS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pls_checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define PLS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pls_checker: next-cycle property failed");

`endif

// ----- rtl/pls_pkg.sv -----
// Package of the positional list store: field widths, operation and status codes.
// Used by the interfaces, the top level and the checker; depends on nothing.
`default_nettype none

package pls_pkg;

  // Default list capacity in words.
  localparam int CAPACITY_DEF = 64;

  // Fixed field widths of the request and response words.
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int WORD_W = 64;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;

  // Operation codes; the remaining codes are no-ops.
  typedef enum logic [OP_W-1:0] {
    OP_INS_AT    = 3'd0,
    OP_DEL_AT    = 3'd1,
    OP_INS_AFTER = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_READ      = 3'd4
  } op_t;

  // Response status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_NOKEY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/pls_if.sv -----
// Valid/ready channel interfaces for the request and response words.
// Depends on pls_pkg for the field widths.
`default_nettype none

// Request channel: one operation per word.
interface pls_req_if;
  logic                        valid;
  logic                        ready;
  logic [pls_pkg::OP_W-1:0]    op;
  logic [pls_pkg::POS_W-1:0]   position;
  logic [pls_pkg::WORD_W-1:0]  value;
  logic [pls_pkg::WORD_W-1:0]  key;

  modport source (output valid, output op, output position, output value, output key,
                  input ready);
  modport sink   (input valid, input op, input position, input value, input key,
                  output ready);
endinterface

// Response channel: one result word per operation.
interface pls_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pls_pkg::ST_W-1:0]    status;
  logic [pls_pkg::CNT_W-1:0]   count;
  logic [pls_pkg::WORD_W-1:0]  read_data;
  logic [pls_pkg::CNT_W-1:0]   removed;

  modport source (output valid, output status, output count, output read_data,
                  output removed, input ready);
  modport sink   (input valid, input status, input count, input read_data,
                  input removed, output ready);
endinterface

`default_nettype wire

// ----- rtl/pls_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; contents are not reset.
`default_nettype none

module pls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/positional_list_store.sv -----
// Positional list store: an ordered list of up to CAPACITY 64-bit words in one RAM.
//
// Channels: req (sink) carries op, position, value and key; rsp (source) carries
// status, count, read_data and removed. A word moves when valid and ready are
// both high. Exactly one response word follows each request word, in order.
//
// Sequencing: one operation is worked on at a time. A read passes from acceptance
// through S_RDREQ and S_RDWAIT to S_FIN; a rejected request or a spare code goes
// straight to S_FIN. Insert at position moves (count - position + 1) words and
// delete moves (count - position) words, one word a cycle through the RAM's single
// read and write port; an insert then writes the new word in S_PUT. Insert after
// match first scans up to the match, then shifts; remove matches streams the
// whole list once.
//
// Reset clears the word count and the control state; the RAM is not cleared,
// and only entries below the count are ever read.
// The finished response sits in an output register; while the receiver stalls
// it holds, and the next request is accepted and worked on, waiting at its end
// for the register to free up.
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  pls_req_if.sink   req,
  pls_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Control states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_SHUP   = 9'b000000100,
    S_PUT    = 9'b000001000,
    S_SHDN   = 9'b000010000,
    S_CMPCT  = 9'b000100000,
    S_RDREQ  = 9'b001000000,
    S_RDWAIT = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t                        state, state_next;
  logic [CW-1:0]                 used, used_next;
  logic [CW-1:0]                 slot, slot_next;
  logic [CW-1:0]                 rem, rem_next;
  logic [CW-1:0]                 wr_ptr, wr_ptr_next;
  logic [CW-1:0]                 nrem, nrem_next;
  logic [AW-1:0]                 ra, ra_next;
  logic [AW-1:0]                 pi, pi_next;
  logic                          pv, pv_next;
  logic [pls_pkg::WORD_W-1:0]    value_r, value_r_next;
  logic [pls_pkg::WORD_W-1:0]    key_r, key_r_next;
  logic [pls_pkg::WORD_W-1:0]    rdata_r, rdata_r_next;
  pls_pkg::status_t              st_r, st_r_next;

  // Output register.
  logic                          out_valid, out_valid_next;
  logic                          out_load;

  // RAM port signals.
  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [pls_pkg::WORD_W-1:0]    mem_wdata, mem_rdata;

  // Request decode helpers.
  logic [EW-1:0]                 pos_e, used_e;
  logic                          walking, issue, walk_done, hit;
  logic [CW-1:0]                 pos_m1;

  pls_ram #(
    .WIDTH (pls_pkg::WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign pos_e     = EW'(req.position);
  assign used_e    = EW'(used);
  assign pos_m1    = CW'(pos_e - EW'(1));

  // The walk states issue one read a cycle while reads remain.
  assign walking   = (state == S_SCAN) || (state == S_SHUP) ||
                     (state == S_SHDN) || (state == S_CMPCT);
  assign issue     = walking && (rem != '0);
  assign walk_done = (rem == '0) && !pv;
  assign hit       = (mem_rdata == key_r);
  assign mem_re    = issue || (state == S_RDREQ);
  assign mem_raddr = ra;
  assign out_load  = (state == S_FIN) && (!out_valid || rsp.ready);

  // Next-state and datapath logic.
  always_comb begin
    state_next   = state;
    used_next    = used;
    slot_next    = slot;
    rem_next     = rem;
    wr_ptr_next  = wr_ptr;
    nrem_next    = nrem;
    ra_next      = ra;
    pi_next      = pi;
    pv_next      = 1'b0;
    value_r_next = value_r;
    key_r_next   = key_r;
    rdata_r_next = rdata_r;
    st_r_next    = st_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = mem_rdata;

    // Shared read stepping of the walk states.
    if (issue) begin
      rem_next = rem - CW'(1);
      ra_next  = (state == S_SHUP) ? ra - AW'(1) : ra + AW'(1);
      pv_next  = 1'b1;
      pi_next  = ra;
    end

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          value_r_next = req.value;
          key_r_next   = req.key;
          rdata_r_next = '0;
          nrem_next    = '0;
          wr_ptr_next  = '0;
          st_r_next    = pls_pkg::ST_OK;
          state_next   = S_FIN;
          unique case (pls_pkg::op_t'(req.op))
            pls_pkg::OP_INS_AT: begin
              if (pos_e == '0 || pos_e > used_e + EW'(1)) begin
                st_r_next = pls_pkg::ST_BADPOS;
              end else if (used == CAP_C) begin
                st_r_next = pls_pkg::ST_FULL;
              end else begin
                slot_next  = pos_m1;
                rem_next   = used - pos_m1;
                ra_next    = AW'(used - CW'(1));
                state_next = S_SHUP;
              end
            end
            pls_pkg::OP_DEL_AT: begin
              if (pos_e == '0 || pos_e > used_e) begin
                st_r_next = pls_pkg::ST_BADPOS;
              end else begin
                slot_next  = pos_m1;
                rem_next   = used - pos_m1 - CW'(1);
                ra_next    = AW'(pos_m1 + CW'(1));
                state_next = S_SHDN;
              end
            end
            pls_pkg::OP_INS_AFTER: begin
              if (used == '0) begin
                st_r_next = pls_pkg::ST_NOKEY;
              end else begin
                rem_next   = used;
                ra_next    = '0;
                state_next = S_SCAN;
              end
            end
            pls_pkg::OP_REMOVE: begin
              if (used == '0) begin
                st_r_next = pls_pkg::ST_NOKEY;
              end else begin
                rem_next   = used;
                ra_next    = '0;
                state_next = S_CMPCT;
              end
            end
            pls_pkg::OP_READ: begin
              if (pos_e == '0 || pos_e > used_e) begin
                st_r_next = pls_pkg::ST_BADPOS;
              end else begin
                ra_next    = AW'(pos_m1);
                state_next = S_RDREQ;
              end
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end

      // Look for the first word equal to the key, then open a gap after it.
      S_SCAN: begin
        if (pv && hit) begin
          pv_next = 1'b0;
          if (used == CAP_C) begin
            st_r_next  = pls_pkg::ST_FULL;
            state_next = S_FIN;
          end else begin
            slot_next  = CW'(pi) + CW'(1);
            rem_next   = used - (CW'(pi) + CW'(1));
            ra_next    = AW'(used - CW'(1));
            state_next = S_SHUP;
          end
        end else if (walk_done) begin
          st_r_next  = pls_pkg::ST_NOKEY;
          state_next = S_FIN;
        end
      end

      // Move words up by one, from the top down to the slot.
      S_SHUP: begin
        if (pv) begin
          mem_we    = 1'b1;
          mem_waddr = pi + AW'(1);
        end
        if (walk_done) begin
          state_next = S_PUT;
        end
      end

      // Drop the new word into the opened slot.
      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(slot);
        mem_wdata  = value_r;
        used_next  = used + CW'(1);
        state_next = S_FIN;
      end

      // Move words above the slot down by one.
      S_SHDN: begin
        if (pv) begin
          mem_we    = 1'b1;
          mem_waddr = pi - AW'(1);
        end
        if (walk_done) begin
          used_next  = used - CW'(1);
          state_next = S_FIN;
        end
      end

      // Stream the list once, keeping only words that differ from the key.
      S_CMPCT: begin
        if (pv) begin
          if (hit) begin
            nrem_next = nrem + CW'(1);
          end else begin
            mem_we      = 1'b1;
            mem_waddr   = AW'(wr_ptr);
            wr_ptr_next = wr_ptr + CW'(1);
          end
        end
        if (walk_done) begin
          used_next  = wr_ptr;
          st_r_next  = (nrem == '0) ? pls_pkg::ST_NOKEY : pls_pkg::ST_OK;
          state_next = S_FIN;
        end
      end

      S_RDREQ: begin
        state_next = S_RDWAIT;
      end

      S_RDWAIT: begin
        rdata_r_next = mem_rdata;
        state_next   = S_FIN;
      end

      // Wait for the output register to be free.
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the word is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      pv        <= pv_next;
      out_valid <= out_valid_next;
    end
  end

  // Working registers of the current operation.
  always_ff @(posedge clk) begin
    slot    <= slot_next;
    rem     <= rem_next;
    wr_ptr  <= wr_ptr_next;
    nrem    <= nrem_next;
    ra      <= ra_next;
    pi      <= pi_next;
    value_r <= value_r_next;
    key_r   <= key_r_next;
    rdata_r <= rdata_r_next;
    st_r    <= st_r_next;
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status    <= st_r;
      rsp.count     <= pls_pkg::CNT_W'(used);
      rsp.read_data <= rdata_r;
      rsp.removed   <= pls_pkg::CNT_W'(nrem);
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/pls_checker.sv -----
// Port-level checker of the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store_defines.svh.
`default_nettype none
`include "positional_list_store_defines.svh"

module pls_checker #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [pls_pkg::ST_W-1:0]   rsp_status,
  input wire logic [pls_pkg::CNT_W-1:0]  rsp_count,
  input wire logic [pls_pkg::WORD_W-1:0] rsp_read_data,
  input wire logic [pls_pkg::CNT_W-1:0]  rsp_removed
);

  localparam logic [pls_pkg::CNT_W-1:0] CAP_LOW = pls_pkg::CNT_W'(CAPACITY);

  // A stalled response word holds still.
  `PLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_removed) && $stable(rsp_read_data))

  // Removed words are reported only by a successful operation.
  `PLS_ASSERT_NOW(a_removed_ok, rsp_valid && rsp_removed != '0, rsp_status == pls_pkg::ST_OK)

  // Read data is zero unless the operation succeeded.
  `PLS_ASSERT_NOW(a_rdata_ok, rsp_valid && rsp_read_data != '0, rsp_status == pls_pkg::ST_OK)

  // A full report comes only with the list at capacity.
  `PLS_ASSERT_NOW(a_full_count, rsp_valid && rsp_status == pls_pkg::ST_FULL, rsp_count == CAP_LOW)

endmodule

bind positional_list_store pls_checker #(
  .CAPACITY (CAPACITY)
) u_pls_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_count     (rsp.count),
  .rsp_read_data (rsp.read_data),
  .rsp_removed   (rsp.removed)
);

`default_nettype wire
